// ===== src/lpct_pkg.sv =====
// ----------------------------------------------------------------------------
// lpct_pkg
// Shared types and constants for the launch PID cut timer.
// ----------------------------------------------------------------------------
`default_nettype none

package lpct_pkg;

    // field widths
    localparam int SPEED_W  = 32;
    localparam int ERR_W    = 32;
    localparam int TS_W     = 32;
    localparam int CUT_W    = 16;
    localparam int DRIVE_W  = 23;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 32;
    localparam int MAXSPD_W = 16;
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 48;

    // register indexes
    localparam logic [CFG_AW-1:0] CFG_MAX_SPEED    = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_GAIN_P       = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_GAIN_I       = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_GAIN_D       = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_INTEGRAL_MAX = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_INTEGRAL_MIN = 3'd5;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL_INT,
        S_MUL_P,
        S_MUL_I,
        S_MUL_D,
        S_MUL_CUT,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== src/lpct_serial_mul.sv =====
// ----------------------------------------------------------------------------
// lpct_serial_mul
// Signed shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lpct_serial_mul #(
    parameter int AW = 40,
    parameter int BW = 33
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  wire  [AW-1:0]        i_a,
    input  wire  [BW-1:0]        i_b,
    output logic                 o_done,
    output logic [AW+BW:0]       o_product
);

    localparam int CW = (BW > 1) ? $clog2(BW) : 1;

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_a, n_a;
    logic [AW:0]   r_hi, n_hi;
    logic [BW-1:0] r_lo, n_lo;

    logic [AW+1:0] w_add;
    logic [AW+1:0] w_sum;
    logic          w_last;

    // one partial product step; the sign bit of the multiplier subtracts
    always_comb begin
        w_last = (r_cnt == CW'(BW - 1));
        if (!r_lo[0]) begin
            w_add = '0;
        end else if (w_last) begin
            w_add = -{{2{r_a[AW-1]}}, r_a};
        end else begin
            w_add = {{2{r_a[AW-1]}}, r_a};
        end
        w_sum = {r_hi[AW], r_hi} + w_add;
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_hi   = r_hi;
        n_lo   = r_lo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_a    = i_a;
            n_hi   = '0;
            n_lo   = i_b;
        end else if (r_busy) begin
            n_hi  = w_sum[AW+1:1];
            n_lo  = {w_sum[0], r_lo[BW-1:1]};
            n_cnt = r_cnt + 1'b1;
            if (w_last) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_a  <= n_a;
        r_hi <= n_hi;
        r_lo <= n_lo;
    end

    assign o_done    = r_done;
    assign o_product = {r_hi, r_lo};

endmodule

`default_nettype wire

// ===== src/lpct_serial_div.sv =====
// ----------------------------------------------------------------------------
// lpct_serial_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lpct_serial_div #(
    parameter int NW = 48,
    parameter int DW = 33
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_start,
    input  wire  [NW-1:0] i_num,
    input  wire  [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);

    localparam int CW = $clog2(NW);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [DW-1:0] r_den, n_den;
    logic [DW-1:0] r_rem, n_rem;
    logic [NW-1:0] r_quo, n_quo;

    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic          w_ge;

    // trial subtract of the next numerator bit
    always_comb begin
        w_trial = {r_rem, r_quo[NW-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_ge    = (w_trial >= {1'b0, r_den});
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_den  = r_den;
        n_rem  = r_rem;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_den  = i_den;
            n_rem  = '0;
            n_quo  = i_num;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            n_quo = {r_quo[NW-2:0], w_ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(NW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_den <= n_den;
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

`default_nettype wire

// ===== src/launch_pid_cut_timer_top.sv =====
// Sequence: a divide when dt is nonzero, then up to five multiplies through
//   one shared bit-serial multiplier.
// Throughput: one item at a time; the multiplier sets the pace.
// Reset (synchronous, active low): registers at their defaults, stored error,
//   time and integral at zero, no result pending.
// ----------------------------------------------------------------------------
// launch_pid_cut_timer_top
// Launch-control PID with clamped integral that sizes an ignition cut time.
// ----------------------------------------------------------------------------
`default_nettype none

module launch_pid_cut_timer_top #(
    parameter int FRAC_BITS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // config write port
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_addr,
    input  wire  [31:0] i_cfg_wdata,
    // input items
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // speed[31:0], error_value[63:32], timestamp[95:64], shift_active[96]
    input  wire  [103:0] i_s_axis_tdata,
    // result items
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // cut_fire[0], cut_time[16:1], drive_level[39:17], dt_zero[40]
    output logic [47:0] o_m_axis_tdata
);

    localparam int F   = FRAC_BITS;
    localparam int AW  = (F + 16 > 33) ? F + 16 : 33;
    localparam int BW  = 33;
    localparam int PW  = AW + BW + 1;
    localparam int PS  = PW - F;
    localparam int IW  = PS + 1;
    localparam int ACW = PS + 2;
    localparam int DRW = F + 7;
    localparam int NW  = 32 + F;
    localparam int CMPW = 41;
    localparam logic signed [ACW-1:0] DRIVE_MAX_A = ACW'(99 * (2 ** F));
    localparam logic [DRW-1:0] DRIVE_MAX_D = DRW'(99 * (2 ** F));

    // configuration registers
    logic [15:0]        r_max_speed;
    logic signed [31:0] r_gain_p, r_gain_i, r_gain_d, r_imax, r_imin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed <= 16'hFFFF;
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_imax      <= 32'sh7FFF_FFFF;
            r_imin      <= 32'sh8000_0000;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                lpct_pkg::CFG_MAX_SPEED:    r_max_speed <= i_cfg_wdata[15:0];
                lpct_pkg::CFG_GAIN_P:       r_gain_p    <= i_cfg_wdata;
                lpct_pkg::CFG_GAIN_I:       r_gain_i    <= i_cfg_wdata;
                lpct_pkg::CFG_GAIN_D:       r_gain_d    <= i_cfg_wdata;
                lpct_pkg::CFG_INTEGRAL_MAX: r_imax      <= i_cfg_wdata;
                lpct_pkg::CFG_INTEGRAL_MIN: r_imin      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input fields
    logic [31:0] w_speed, w_err, w_ts;
    logic        w_shift;
    assign w_speed = i_s_axis_tdata[31:0];
    assign w_err   = i_s_axis_tdata[63:32];
    assign w_ts    = i_s_axis_tdata[95:64];
    assign w_shift = i_s_axis_tdata[96];

    lpct_pkg::t_state r_state, n_state;

    logic [31:0]        r_prev_err, r_prev_time, r_isum, r_err;
    logic [31:0]        r_num_abs, r_deriv;
    logic [32:0]        r_dt;
    logic               r_dtz, r_active, r_shift, r_neg, r_issued;
    logic [ACW-1:0]     r_acc;
    logic [DRW-1:0]     r_drive;
    logic [15:0]        r_cut;
    logic               r_out_valid;
    logic [47:0]        r_out_data;

    logic [31:0]        n_prev_err, n_prev_time, n_isum, n_err, n_num_abs, n_deriv;
    logic [32:0]        n_dt;
    logic               n_dtz, n_active, n_shift, n_neg, n_issued;
    logic [ACW-1:0]     n_acc;
    logic [DRW-1:0]     n_drive;
    logic [15:0]        n_cut;
    logic               n_out_valid;
    logic [47:0]        n_out_data;

    // shared units
    logic          w_mul_start, w_mul_done, w_div_start, w_div_done;
    logic [AW-1:0] w_mul_a;
    logic [BW-1:0] w_mul_b;
    logic [PW-1:0] w_prod;
    logic [NW-1:0] w_quot;
    logic [32:0]   w_dt_abs;

    lpct_serial_mul #(.AW(AW), .BW(BW)) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_a       (w_mul_a),
        .i_b       (w_mul_b),
        .o_done    (w_mul_done),
        .o_product (w_prod)
    );

    assign w_dt_abs = r_dt[32] ? (~r_dt + 33'd1) : r_dt;

    lpct_serial_div #(.NW(NW), .DW(33)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   ({r_num_abs, {F{1'b0}}}),
        .i_den   (w_dt_abs),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // arithmetic on the unit results
    logic [32:0]           w_dt_in, w_diff, w_diff_abs;
    logic [CMPW-1:0]       w_spd_x, w_lim_x;
    logic [31:0]           w_deriv_sat;
    logic signed [PS-1:0]  w_ps;
    logic signed [IW-1:0]  w_integ, w_imax_x, w_imin_x;
    logic [31:0]           w_integ_cl;
    logic signed [ACW-1:0] w_o;
    logic [DRW-1:0]        w_drive_cl;
    logic [DRW+6:0]        w_a100;
    logic [15:0]           w_cut_sat;
    logic                  w_q_over;

    always_comb begin
        w_dt_in    = {1'b0, w_ts} - {1'b0, r_prev_time};
        w_diff     = {w_err[31], w_err} - {r_prev_err[31], r_prev_err};
        w_diff_abs = w_diff[32] ? (~w_diff + 33'd1) : w_diff;
        w_spd_x    = CMPW'(w_speed);
        w_lim_x    = CMPW'({r_max_speed, {F{1'b0}}});

        // derivative: truncated quotient, saturated to 32 bit signed
        if (r_neg) begin
            w_q_over    = (|w_quot[NW-1:32]) || (w_quot[31] && (|w_quot[30:0]));
            w_deriv_sat = w_q_over ? 32'h8000_0000 : (~w_quot[31:0] + 32'd1);
        end else begin
            w_q_over    = (|w_quot[NW-1:31]);
            w_deriv_sat = w_q_over ? 32'h7FFF_FFFF : w_quot[31:0];
        end

        // product scaled back, floor rounding
        w_ps = $signed(w_prod[PW-1:F]);

        // integral update: clamp to the upper limit first, then the lower one
        w_imax_x = $signed({{(IW-32){r_imax[31]}}, r_imax});
        w_imin_x = $signed({{(IW-32){r_imin[31]}}, r_imin});
        w_integ  = $signed({{(IW-32){r_isum[31]}}, r_isum}) + $signed({w_ps[PS-1], w_ps});
        if (w_integ > w_imax_x) begin
            // crossed limits: the lower one wins
            w_integ_cl = (r_imax < r_imin) ? r_imin : r_imax;
        end else if (w_integ < w_imin_x) begin
            w_integ_cl = r_imin;
        end else begin
            w_integ_cl = w_integ[31:0];
        end

        // output sum and clamp to 0..99
        w_o = $signed(r_acc) + $signed({{2{w_ps[PS-1]}}, w_ps});
        if (w_o > DRIVE_MAX_A) begin
            w_drive_cl = DRIVE_MAX_D;
        end else if (w_o < 0) begin
            w_drive_cl = '0;
        end else begin
            w_drive_cl = w_o[DRW-1:0];
        end

        w_a100 = {r_drive, 6'b0} + {1'b0, r_drive, 5'b0} + {4'b0, r_drive, 2'b0};

        // cut time: product over 2^(2F), saturated
        w_cut_sat = (|w_prod[PW-1:2*F+16]) ? 16'hFFFF : w_prod[2*F+15:2*F];
    end

    // multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            lpct_pkg::S_MUL_INT: begin
                w_mul_a = AW'($signed(r_err));
                w_mul_b = r_dt;
            end
            lpct_pkg::S_MUL_P: begin
                w_mul_a = AW'($signed(r_gain_p));
                w_mul_b = {r_err[31], r_err};
            end
            lpct_pkg::S_MUL_I: begin
                w_mul_a = AW'($signed(r_gain_i));
                w_mul_b = {r_isum[31], r_isum};
            end
            lpct_pkg::S_MUL_D: begin
                w_mul_a = AW'($signed(r_gain_d));
                w_mul_b = {r_deriv[31], r_deriv};
            end
            lpct_pkg::S_MUL_CUT: begin
                w_mul_a = AW'(w_a100);
                w_mul_b = r_dt;
            end
            default: ;
        endcase
    end

    logic w_in_acc, w_mul_state;
    assign w_in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_mul_state = (r_state == lpct_pkg::S_MUL_INT) || (r_state == lpct_pkg::S_MUL_P)
                      || (r_state == lpct_pkg::S_MUL_I) || (r_state == lpct_pkg::S_MUL_D)
                      || (r_state == lpct_pkg::S_MUL_CUT);
    assign w_mul_start = w_mul_state && !r_issued;
    assign w_div_start = (r_state == lpct_pkg::S_DIV) && !r_issued;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_prev_err  = r_prev_err;
        n_prev_time = r_prev_time;
        n_isum      = r_isum;
        n_err       = r_err;
        n_num_abs   = r_num_abs;
        n_deriv     = r_deriv;
        n_dt        = r_dt;
        n_dtz       = r_dtz;
        n_active    = r_active;
        n_shift     = r_shift;
        n_neg       = r_neg;
        n_acc       = r_acc;
        n_drive     = r_drive;
        n_cut       = r_cut;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        n_issued    = r_issued;
        if (w_mul_start || w_div_start) begin
            n_issued = 1'b1;
        end
        if (w_mul_done || w_div_done) begin
            n_issued = 1'b0;
        end

        case (r_state)
            lpct_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_prev_err  = w_err;
                    n_prev_time = w_ts;
                    n_err       = w_err;
                    n_shift     = w_shift;
                    n_dt        = w_dt_in;
                    n_dtz       = (w_dt_in == 33'd0);
                    n_num_abs   = w_diff_abs[31:0];
                    n_neg       = w_diff[32] ^ w_dt_in[32];
                    n_active    = (w_spd_x <= w_lim_x);
                    n_deriv     = '0;
                    n_drive     = '0;
                    n_cut       = '0;
                    if (w_dt_in != 33'd0) begin
                        n_state = lpct_pkg::S_DIV;
                    end else if (w_spd_x <= w_lim_x) begin
                        n_state = lpct_pkg::S_MUL_INT;
                    end else begin
                        n_state = lpct_pkg::S_DONE;
                    end
                end
            end
            lpct_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_deriv = w_deriv_sat;
                    n_state = r_active ? lpct_pkg::S_MUL_INT : lpct_pkg::S_DONE;
                end
            end
            lpct_pkg::S_MUL_INT: begin
                if (w_mul_done) begin
                    n_isum  = w_integ_cl;
                    n_state = lpct_pkg::S_MUL_P;
                end
            end
            lpct_pkg::S_MUL_P: begin
                if (w_mul_done) begin
                    n_acc   = {{2{w_ps[PS-1]}}, w_ps};
                    n_state = lpct_pkg::S_MUL_I;
                end
            end
            lpct_pkg::S_MUL_I: begin
                if (w_mul_done) begin
                    n_acc   = w_o;
                    n_state = lpct_pkg::S_MUL_D;
                end
            end
            lpct_pkg::S_MUL_D: begin
                if (w_mul_done) begin
                    n_drive = w_drive_cl;
                    if (!r_dt[32] && !r_dtz) begin
                        n_state = lpct_pkg::S_MUL_CUT;
                    end else begin
                        n_state = lpct_pkg::S_DONE;
                    end
                end
            end
            lpct_pkg::S_MUL_CUT: begin
                if (w_mul_done) begin
                    n_cut   = w_cut_sat;
                    n_state = lpct_pkg::S_DONE;
                end
            end
            lpct_pkg::S_DONE: begin
                // hand off once the output register is free
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {7'b0, r_dtz, 23'(r_drive), r_cut,
                                   (r_cut != 16'd0) && !r_shift};
                    n_state     = lpct_pkg::S_IDLE;
                end
            end
            default: n_state = lpct_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lpct_pkg::S_IDLE;
            r_prev_err  <= '0;
            r_prev_time <= '0;
            r_isum      <= '0;
            r_drive     <= '0;
            r_out_valid <= 1'b0;
            r_issued    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prev_err  <= n_prev_err;
            r_prev_time <= n_prev_time;
            r_isum      <= n_isum;
            r_drive     <= n_drive;
            r_out_valid <= n_out_valid;
            r_issued    <= n_issued;
        end
        r_err      <= n_err;
        r_num_abs  <= n_num_abs;
        r_deriv    <= n_deriv;
        r_dt       <= n_dt;
        r_dtz      <= n_dtz;
        r_active   <= n_active;
        r_shift    <= n_shift;
        r_neg      <= n_neg;
        r_acc      <= n_acc;
        r_cut      <= n_cut;
        r_out_data <= n_out_data;
    end

    assign o_s_axis_tready = (r_state == lpct_pkg::S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    // divider only runs on a nonzero dt
    a_div_dt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lpct_pkg::S_DIV) |-> !r_dtz) else $error("divider with zero dt");

    // a fired cut always carries a duration
    a_fire_cut: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[0]) |-> (o_m_axis_tdata[16:1] != 16'd0))
        else $error("cut fired with zero time");

    // drive level stays within the clamp
    a_drive_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drive <= DRIVE_MAX_D) else $error("drive above clamp");

    // a result only appears out of the final state
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state == lpct_pkg::S_DONE))
        else $error("result without completion");
`endif

endmodule

`default_nettype wire
